### sv/banded_sequence_count_dp_unit_defines.svh
// Assertion macros for the banded sequence counter.
// Used by bscdp_ctrl and bscdp_dpath; expects aclk and aresetn in scope.
`ifndef BANDED_SEQUENCE_COUNT_DP_UNIT_DEFINES_SVH
`define BANDED_SEQUENCE_COUNT_DP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bscdp_pkg.sv
// Shared types and constants for the banded sequence counter.
// No dependencies; imported by bscdp_ctrl, bscdp_dpath and the top level.
`default_nettype none

package bscdp_pkg;

    localparam int VALUE_W = 8;
    localparam int COUNT_W = 30;
    localparam int CFG_W   = 8;

    localparam logic [CFG_W-1:0] MAX_VALUE_RST = 8'd100;
    localparam logic [31:0]      MODULUS       = 32'd1000000007;
    localparam logic [31:0]      MODULUS_X2    = 32'd2000000014;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;  // write zero during the post-reset sweep
        logic start;     // capture the input item, reset window and total
        logic rd_en;     // read the old count at rd_addr
        logic shift;     // advance the three-entry window
        logic proc_en;   // compute and write the new count at wr_addr
        logic acc_en;    // fold the last computed count into the total
        logic out_load;  // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // result register empty or being drained
    } status_t;

endpackage

`default_nettype wire

### sv/bscdp_dpath.sv
// Datapath of the banded sequence counter: count memory, window, modular adders,
// configuration and result registers. Depends on bscdp_pkg and the assertion macros.
`default_nettype none
`include "banded_sequence_count_dp_unit_defines.svh"

module bscdp_dpath #(
    parameter int MAX_VALUES = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bscdp_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic [7:0]                    s_tdata,   // [7:0] value
    input  wire logic                          s_tuser,   // [0] first
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // [29:0] count, [31:30] zero
    input  wire bscdp_pkg::cmd_t               cmd,
    output bscdp_pkg::status_t                 status,
    input  wire logic [$clog2(MAX_VALUES)-1:0] rd_addr,
    input  wire logic [$clog2(MAX_VALUES)-1:0] wr_addr
);
    import bscdp_pkg::*;

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = (AW + 2 > 9) ? AW + 2 : 9;

    logic [COUNT_W-1:0] ways_mem [MAX_VALUES];
    logic [COUNT_W-1:0] rd_data_reg;

    logic [CFG_W-1:0]   max_value_reg, max_value_next;
    logic [VALUE_W-1:0] value_reg;
    logic               first_reg;
    logic [CW-1:0]      m_reg;
    logic [CW-1:0]      m_eff;
    logic [COUNT_W-1:0] lo_reg, mid_reg;
    logic [COUNT_W-1:0] c_reg, c_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0] count_reg;

    logic [CW-1:0]      jp1, jp2;
    logic [COUNT_W-1:0] hi_val;
    logic [31:0]        sum3, sum3_red;
    logic [30:0]        acc_sum;
    logic [COUNT_W-1:0] wr_data;
    logic               wr_en;

    assign cfg_ready = 1'b1;
    assign max_value_next = (cfg_valid && cfg_ready) ? cfg_data : max_value_reg;

    // effective maximum: min(max_value, MAX_VALUES)
    assign m_eff = (CW'(max_value_reg) > CW'(MAX_VALUES)) ? CW'(MAX_VALUES)
                                                          : CW'(max_value_reg);

    // entry j (0-based) holds value j+1; window is lo=j-1, mid=j, hi=j+1
    assign jp1    = CW'(wr_addr) + CW'(1);
    assign jp2    = CW'(wr_addr) + CW'(2);
    assign hi_val = (jp2 <= m_reg) ? rd_data_reg : '0;
    assign sum3   = 32'(lo_reg) + 32'(mid_reg) + 32'(hi_val);

    always_comb begin
        if (sum3 >= MODULUS_X2) begin
            sum3_red = sum3 - MODULUS_X2;
        end else if (sum3 >= MODULUS) begin
            sum3_red = sum3 - MODULUS;
        end else begin
            sum3_red = sum3;
        end
    end

    always_comb begin
        c_next = '0;
        if (jp1 <= m_reg && (value_reg == '0 || CW'(value_reg) == jp1)) begin
            c_next = first_reg ? COUNT_W'(1) : sum3_red[COUNT_W-1:0];
        end
    end

    assign acc_sum    = 31'(total_reg) + 31'(c_reg);
    assign total_next = (acc_sum >= MODULUS[30:0]) ? COUNT_W'(acc_sum - MODULUS[30:0])
                                                  : acc_sum[COUNT_W-1:0];

    assign wr_en   = cmd.clear_wr || cmd.proc_en;
    assign wr_data = cmd.clear_wr ? '0 : c_next;

    // count memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ways_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= ways_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            value_reg <= s_tdata[VALUE_W-1:0];
            first_reg <= s_tuser;
            m_reg     <= m_eff;
            mid_reg   <= '0;
        end else if (cmd.shift) begin
            lo_reg  <= mid_reg;
            mid_reg <= rd_data_reg;
        end
        if (cmd.out_load) begin
            count_reg <= total_reg;
        end
    end

    assign m_tvalid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg <= MAX_VALUE_RST;
            m_tvalid_reg  <= 1'b0;
            total_reg     <= '0;
            c_reg         <= '0;
        end else begin
            max_value_reg <= max_value_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cmd.start) begin
                total_reg <= '0;
            end else if (cmd.acc_en) begin
                total_reg <= total_next;
            end
            if (cmd.proc_en) begin
                c_reg <= c_next;
            end
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = {2'b00, count_reg};

    `BSC_ASSERT_NOW(a_load_free, cmd.out_load, !m_tvalid_reg || m_tready, "result overwritten")
    `BSC_ASSERT_NOW(a_total_mod, 1'b1, total_reg < MODULUS[COUNT_W-1:0], "total not reduced")
    `BSC_ASSERT_NOW(a_count_mod, cmd.acc_en, c_reg < MODULUS[COUNT_W-1:0], "count not reduced")

endmodule

`default_nettype wire

### sv/bscdp_ctrl.sv
// Controller of the banded sequence counter: clearing sweep, per-item sweep
// sequencing and result handoff. Depends on bscdp_pkg and the assertion macros.
`default_nettype none
`include "banded_sequence_count_dp_unit_defines.svh"

module bscdp_ctrl #(
    parameter int MAX_VALUES = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire bscdp_pkg::status_t            status,
    output bscdp_pkg::cmd_t                    cmd,
    output logic [$clog2(MAX_VALUES)-1:0]      rd_addr,
    output logic [$clog2(MAX_VALUES)-1:0]      wr_addr
);
    import bscdp_pkg::*;

    localparam int AW = $clog2(MAX_VALUES);
    localparam int SW = $clog2(MAX_VALUES + 3);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [SW-1:0] step_m2;

    assign step_m2 = step_reg - SW'(2);
    assign rd_addr = step_reg[AW-1:0];
    assign wr_addr = (state_reg == ST_CLEAR) ? step_reg[AW-1:0] : step_m2[AW-1:0];
    assign s_tready = (state_reg == ST_IDLE);

    // RUN step s: read entry s, process entry s-2, accumulate entry s-3
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (step_reg == SW'(MAX_VALUES - 1)) begin
                    state_next = ST_IDLE;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                cmd.rd_en   = step_reg < SW'(MAX_VALUES);
                cmd.shift   = step_reg >= SW'(1) && step_reg <= SW'(MAX_VALUES + 1);
                cmd.proc_en = step_reg >= SW'(2) && step_reg <= SW'(MAX_VALUES + 1);
                cmd.acc_en  = step_reg >= SW'(3);
                if (step_reg == SW'(MAX_VALUES + 2)) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `BSC_ASSERT_NEXT(a_accept_run, s_tvalid && s_tready, state_reg == ST_RUN && step_reg == '0, "item not started")
    `BSC_ASSERT_NOW(a_acc_follows, cmd.acc_en, $past(cmd.proc_en), "accumulate without a computed count")

endmodule

`default_nettype wire

### sv/banded_sequence_count_dp_unit.sv
// Banded sequence counter: one count per value, updated by a sweep over the count memory.
// The result is registered after the memory sweep, which reads, processes and accumulates
// one entry per cycle; the controller then waits in DONE until the result register is free.
// Items: one at a time, accepted only in idle; a held result stalls only the next finish.
// Reset: synchronous; a clearing pass zeroes every count memory entry, s_tready low.
`default_nettype none

module banded_sequence_count_dp_unit #(
    parameter int MAX_VALUES = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,   // [7:0] max_value
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] value
    input  wire logic        s_tuser,    // [0] first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // [29:0] count, [31:30] zero
);
    import bscdp_pkg::*;

    localparam int AW = $clog2(MAX_VALUES);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    bscdp_ctrl #(
        .MAX_VALUES (MAX_VALUES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    bscdp_dpath #(
        .MAX_VALUES (MAX_VALUES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

endmodule

`default_nettype wire
